// ===== src/mtrd_pkg.sv =====
package mtrd_pkg;

    // Generator geometry
    localparam int unsigned TW_N  = 624;
    localparam int unsigned TW_M  = 397;
    localparam int unsigned IDX_W = 10;

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx IDX_LAST     = t_idx'(TW_N - 1);
    localparam t_idx IDX_N        = t_idx'(TW_N);       // seeded, twist due
    localparam t_idx IDX_UNSEEDED = t_idx'(TW_N + 1);   // never seeded
    localparam t_idx IDX_WRAP     = t_idx'(TW_N - TW_M);
    localparam t_idx IDX_M        = t_idx'(TW_M);

    // Generator constants
    localparam logic [31:0] TW_UPPER        = 32'h8000_0000;
    localparam logic [31:0] TW_LOWER        = 32'h7fff_ffff;
    localparam logic [31:0] TW_MATRIX       = 32'h9908_b0df;
    localparam logic [31:0] TW_DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] FILL_MULT       = 32'd1812433253;
    localparam logic [31:0] TEMPER_B        = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C        = 32'hefc6_0000;

    // Command codes
    localparam logic [1:0] CMD_RESEED = 2'd0;
    localparam logic [1:0] CMD_RAW    = 2'd1;
    localparam logic [1:0] CMD_RANGED = 2'd2;

    // Request bundle toward the state memory
    typedef struct packed {
        logic        rd1_en;
        t_idx        rd1_addr;
        logic        rd2_en;
        t_idx        rd2_addr;
        logic        wr_en;
        t_idx        wr_addr;
        logic [31:0] wr_data;
    } t_mem_req;

    // Output tempering
    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== src/mtrd_state_mem.sv =====
module mtrd_state_mem (
    input  logic               i_clk,
    input  mtrd_pkg::t_mem_req i_req,
    output logic [31:0]        o_rd1_data,
    output logic [31:0]        o_rd2_data
);
    import mtrd_pkg::*;

    logic [31:0] r_mem [0:TW_N-1];
    logic [31:0] r_rd1_data;
    logic [31:0] r_rd2_data;

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd1_en) begin
            r_rd1_data <= r_mem[i_req.rd1_addr];
        end
        if (i_req.rd2_en) begin
            r_rd2_data <= r_mem[i_req.rd2_addr];
        end
    end

    assign o_rd1_data = r_rd1_data;
    assign o_rd2_data = r_rd2_data;

endmodule

// ===== src/mtrd_divider.sv =====
module mtrd_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);
    import mtrd_pkg::*;

    localparam int unsigned DIV_STEPS = 31;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [30:0]      r_num;
    logic [31:0]      r_rem;
    logic [31:0]      r_div;
    logic [32:0]      trial;
    logic [32:0]      diff;
    logic [31:0]      n_rem;

    // Restoring step: shift in one dividend bit, subtract when it fits
    assign trial = {r_rem, r_num[30]};
    assign diff  = trial - {1'b0, r_div};
    assign n_rem = (trial >= {1'b0, r_div}) ? diff[31:0] : trial[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== src/mersenne_twister_ranged_draw_core.sv =====
// Channel   | Dir | Signals                         | Contents
// ----------+-----+---------------------------------+-------------------------------------
// command   | in  | i_s_tvalid/o_s_tready           | tuser[1:0] cmd; tdata min, max
// result    | out | o_m_tvalid/i_m_tready           | tdata[31:0] value; tuser[0] range_error
// seed      | in  | i_seed_we/i_seed_wdata          | seed word, written when we is high
//
// One transaction at a time. A ranged draw waits on the 31-step restoring remainder
// unit; a reseed runs the multiply chain of the fill (ST_FILL_X, ST_FILL_M, ST_FILL_W
// per word). Every 624th draw adds a twist (read, then write, per state word through
// the two-read memory).
// The first draw after reset fills with the default seed first, adding the fill time.
// Reset is synchronous; the result register holds while i_m_tready is low.
module mersenne_twister_ranged_draw_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] min_value, [63:32] max_value
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] value
    output logic        o_m_tuser,   // [0] range_error
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_wdata
);
    import mtrd_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_FILL0    = 4'd1;
    localparam logic [3:0] ST_FILL_X   = 4'd2;
    localparam logic [3:0] ST_FILL_M   = 4'd3;
    localparam logic [3:0] ST_FILL_W   = 4'd4;
    localparam logic [3:0] ST_TW_LOAD  = 4'd5;
    localparam logic [3:0] ST_TW_RD    = 4'd6;
    localparam logic [3:0] ST_TW_WR    = 4'd7;
    localparam logic [3:0] ST_RD_ISSUE = 4'd8;
    localparam logic [3:0] ST_RD_TEMP  = 4'd9;
    localparam logic [3:0] ST_EVAL     = 4'd10;
    localparam logic [3:0] ST_DIV_WAIT = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    logic [3:0]  r_state;
    logic [31:0] r_seed;
    t_idx        r_widx;
    t_idx        r_k;
    logic [31:0] r_prev;
    logic [31:0] r_x;
    logic [31:0] r_prod;
    logic [31:0] r_cur;
    logic [1:0]  r_cmd;
    logic [31:0] r_lo;
    logic [31:0] r_hi;
    logic [30:0] r_draw;
    logic [31:0] r_res_value;
    logic        r_res_err;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic        r_out_err;

    t_mem_req    mem_req;
    logic [31:0] rd1_data;
    logic [31:0] rd2_data;
    logic [31:0] fill_val;
    logic [31:0] tw_y;
    logic [31:0] tw_val;
    t_idx        tw_addr1;
    t_idx        tw_addr2;
    logic [31:0] tempered;
    logic        swap;
    logic [31:0] lo_ord;
    logic [31:0] hi_ord;
    logic [31:0] range;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_rem;
    logic        in_accept;

    assign in_accept = i_s_tvalid && o_s_tready;

    // Fill recurrence and twist datapath
    assign fill_val = r_prod + 32'(r_k);
    assign tw_y     = (r_cur & TW_UPPER) | (rd1_data & TW_LOWER);
    assign tw_val   = rd2_data ^ (tw_y >> 1) ^ (tw_y[0] ? TW_MATRIX : 32'd0);
    assign tw_addr1 = (r_k == IDX_LAST) ? '0 : r_k + 1'b1;
    assign tw_addr2 = (r_k < IDX_WRAP) ? r_k + IDX_M : r_k - IDX_WRAP;
    assign tempered = temper(rd1_data);

    // Ranged draw: order bounds by signed compare, exact unsigned width
    assign swap      = $signed(r_lo) > $signed(r_hi);
    assign lo_ord    = swap ? r_hi : r_lo;
    assign hi_ord    = swap ? r_lo : r_hi;
    assign range     = hi_ord - lo_ord;
    assign div_start = (r_state == ST_EVAL) && (r_cmd == CMD_RANGED) && (range != '0);

    // Memory access per state
    always_comb begin
        mem_req = '0;
        unique case (r_state)
            ST_FILL0: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = '0;
                mem_req.wr_data = r_prev;
            end
            ST_FILL_W: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_k;
                mem_req.wr_data = fill_val;
            end
            ST_TW_LOAD: begin
                mem_req.rd1_en   = 1'b1;
                mem_req.rd1_addr = '0;
            end
            ST_TW_RD: begin
                mem_req.rd1_en   = 1'b1;
                mem_req.rd1_addr = tw_addr1;
                mem_req.rd2_en   = 1'b1;
                mem_req.rd2_addr = tw_addr2;
            end
            ST_TW_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_k;
                mem_req.wr_data = tw_val;
            end
            ST_RD_ISSUE: begin
                mem_req.rd1_en   = 1'b1;
                mem_req.rd1_addr = r_widx;
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    mtrd_state_mem u_mem (
        .i_clk      (i_clk),
        .i_req      (mem_req),
        .o_rd1_data (rd1_data),
        .o_rd2_data (rd2_data)
    );

    mtrd_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_draw),
        .i_divisor  (range),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= TW_DEFAULT_SEED;
        end else if (i_seed_we) begin
            r_seed <= i_seed_wdata;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_widx  <= IDX_UNSEEDED;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_cmd <= i_s_tuser;
                        r_lo  <= i_s_tdata[31:0];
                        r_hi  <= i_s_tdata[63:32];
                        unique case (i_s_tuser) inside
                            CMD_RESEED: begin
                                r_prev  <= r_seed;
                                r_state <= ST_FILL0;
                            end
                            CMD_RAW, CMD_RANGED: begin
                                if (r_widx == IDX_UNSEEDED) begin
                                    r_prev  <= TW_DEFAULT_SEED;
                                    r_state <= ST_FILL0;
                                end else if (r_widx == IDX_N) begin
                                    r_state <= ST_TW_LOAD;
                                end else begin
                                    r_state <= ST_RD_ISSUE;
                                end
                            end
                            default: begin
                                r_res_value <= '0;
                                r_res_err   <= 1'b0;
                                r_state     <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_FILL0: begin
                    r_k     <= t_idx'(1);
                    r_state <= ST_FILL_X;
                end
                ST_FILL_X: begin
                    r_x     <= r_prev ^ (r_prev >> 30);
                    r_state <= ST_FILL_M;
                end
                ST_FILL_M: begin
                    r_prod  <= r_x * FILL_MULT;
                    r_state <= ST_FILL_W;
                end
                ST_FILL_W: begin
                    r_prev <= fill_val;
                    if (r_k == IDX_LAST) begin
                        r_widx <= IDX_N;
                        if (r_cmd == CMD_RESEED) begin
                            r_res_value <= '0;
                            r_res_err   <= 1'b0;
                            r_state     <= ST_DONE;
                        end else begin
                            r_state <= ST_TW_LOAD;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_FILL_X;
                    end
                end
                ST_TW_LOAD: begin
                    r_k     <= '0;
                    r_state <= ST_TW_RD;
                end
                ST_TW_RD: begin
                    // read data still holds word k from the previous read
                    r_cur   <= rd1_data;
                    r_state <= ST_TW_WR;
                end
                ST_TW_WR: begin
                    if (r_k == IDX_LAST) begin
                        r_widx  <= '0;
                        r_state <= ST_RD_ISSUE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_TW_RD;
                    end
                end
                ST_RD_ISSUE: begin
                    r_widx  <= r_widx + 1'b1;
                    r_state <= ST_RD_TEMP;
                end
                ST_RD_TEMP: begin
                    r_draw  <= tempered[31:1];
                    r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (r_cmd == CMD_RAW) begin
                        r_res_value <= {1'b0, r_draw};
                        r_res_err   <= 1'b0;
                        r_state     <= ST_DONE;
                    end else if (range == '0) begin
                        r_res_value <= lo_ord;
                        r_res_err   <= 1'b1;
                        r_state     <= ST_DONE;
                    end else begin
                        r_lo    <= lo_ord;
                        r_state <= ST_DIV_WAIT;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        r_res_value <= r_lo + div_rem;
                        r_res_err   <= 1'b0;
                        r_state     <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_DONE && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
                r_out_value <= r_res_value;
                r_out_err   <= r_res_err;
            end
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_err;

    // Checks
    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_widx <= IDX_UNSEEDED)
        else $error("word index beyond unseeded marker");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV_WAIT)
        else $error("remainder finished outside its wait state");

    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.wr_en && (mem_req.rd1_en || mem_req.rd2_en)))
        else $error("state memory read and write in the same cycle");

    a_twist_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TW_WR && r_k == IDX_LAST) |=>
        (r_widx == '0 && r_state == ST_RD_ISSUE))
        else $error("twist did not hand over to the draw read");

    a_read_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RD_ISSUE |-> r_widx < IDX_N)
        else $error("draw read with exhausted state");

endmodule

// ===== tb/mersenne_twister_ranged_draw_core_tb.sv =====
module mersenne_twister_ranged_draw_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtrd_pkg::*;

    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned PHASE_ITEMS  = 240;
    localparam logic [31:0] BOUND_VALS [4] = '{
        32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff
    };

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_draw_req;

    typedef struct {
        logic [31:0] value;
        logic        range_error;
    } t_draw_res;

    // DUT connections, all inputs known from time zero
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [63:0] s_data     = '0;
    logic [1:0]  s_user     = CMD_RAW;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic [31:0] m_data;
    logic        m_user;
    logic        seed_we    = 1'b0;
    logic [31:0] seed_wdata = '0;

    // Generator shadow state
    logic [31:0] mt_words [TW_N];
    int unsigned mt_pos      = TW_N + 1;
    logic [31:0] seed_shadow = TW_DEFAULT_SEED;

    // Bookkeeping
    t_draw_req   cmd_backlog [$];
    t_draw_res   expected_draws [$];
    t_draw_req   drive_req;
    t_draw_req   taken_req;
    t_draw_res   want_res;
    bit          cmd_taken    = 1'b0;
    bit          idle_on      = 1'b1;
    int unsigned send_gap     = 0;
    int unsigned recv_stall   = 0;
    int unsigned queued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned fail_cnt     = 0;
    int unsigned cycle_cnt    = 0;

    mersenne_twister_ranged_draw_core dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .o_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .o_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .o_m_tdata    (m_data),
        .o_m_tuser    (m_user),
        .i_seed_we    (seed_we),
        .i_seed_wdata (seed_wdata)
    );

    always #5 clk = ~clk;

    // Fill the state table from a seed word
    function automatic void mt_fill(input logic [31:0] s);
        logic [31:0] p;
        mt_words[0] = s;
        for (int unsigned i = 1; i < TW_N; i++) begin
            p = mt_words[i-1];
            mt_words[i] = FILL_MULT * (p ^ (p >> 30)) + 32'(i);
        end
        mt_pos = TW_N;
    endfunction

    // Regenerate all 624 words in place
    function automatic void mt_twist();
        logic [31:0] y;
        for (int unsigned k = 0; k < TW_N; k++) begin
            y = (mt_words[k] & TW_UPPER) | (mt_words[(k + 1) % TW_N] & TW_LOWER);
            mt_words[k] = mt_words[(k + TW_M) % TW_N] ^ (y >> 1)
                        ^ (y[0] ? TW_MATRIX : 32'h0);
        end
        mt_pos = 0;
    endfunction

    // Next tempered word, top 31 bits; seeds itself when never seeded
    function automatic logic [30:0] mt_draw31();
        logic [31:0] y;
        if (mt_pos >= TW_N) begin
            if (mt_pos != TW_N)
                mt_fill(TW_DEFAULT_SEED);
            mt_twist();
        end
        y = mt_words[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y[31:1];
    endfunction

    // Expected result of one command, advancing the shadow state
    function automatic t_draw_res predict_draw(input t_draw_req req);
        t_draw_res   res;
        logic [31:0] draw;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] span;
        res.value       = '0;
        res.range_error = 1'b0;
        lo = req.lo;
        hi = req.hi;
        case (req.cmd)
            CMD_RESEED: mt_fill(seed_shadow);
            CMD_RAW:    res.value = {1'b0, mt_draw31()};
            CMD_RANGED: begin
                draw = {1'b0, mt_draw31()};
                // put bounds in signed order
                if ($signed(lo) > $signed(hi)) begin
                    span = lo;
                    lo   = hi;
                    hi   = span;
                end
                span = hi - lo;
                if (span == '0) begin
                    res.value       = lo;
                    res.range_error = 1'b1;
                end else begin
                    res.value = lo + draw % span;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    function automatic void push_cmd(input logic [1:0] cmd, input logic [31:0] lo,
                                     input logic [31:0] hi);
        t_draw_req r;
        r.cmd = cmd;
        r.lo  = lo;
        r.hi  = hi;
        cmd_backlog.push_back(r);
        queued_cnt++;
    endfunction

    // Random command: mostly draws, a few reseeds and unused codes
    function automatic t_draw_req rand_cmd();
        t_draw_req   r;
        int unsigned sel;
        r.lo  = $urandom();
        r.hi  = $urandom();
        r.cmd = CMD_RANGED;
        sel   = $urandom_range(0, 199);
        if (sel < 3) begin
            r.cmd = CMD_RESEED;
        end else if (sel < 9) begin
            r.cmd = CMD_UNUSED;
        end else if (sel < 85) begin
            r.cmd = CMD_RAW;
        end else begin
            case ($urandom_range(0, 9))
                0:    r.hi = r.lo;
                1, 2: r.hi = r.lo + $urandom_range(1, 16);
                3:    r.hi = r.lo - $urandom_range(1, 16);
                4: begin
                    r.lo = BOUND_VALS[$urandom_range(0, 3)];
                    r.hi = BOUND_VALS[$urandom_range(0, 3)];
                end
                5:    r.hi = r.lo ^ (32'h1 << $urandom_range(0, 31));
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic write_seed(input logic [31:0] v);
        repeat (4) @(negedge clk);
        seed_we    <= 1'b1;
        seed_wdata <= v;
        @(negedge clk);
        seed_we     <= 1'b0;
        seed_shadow  = v;
    endtask

    // Block until every queued command was taken and answered
    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_cnt != queued_cnt || expected_draws.size() != 0);
    endtask

    // Command driver
    always @(negedge clk) begin
        if (rst_n && (!s_valid || cmd_taken)) begin
            cmd_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                drive_req = cmd_backlog.pop_front();
                s_data  <= {drive_req.hi, drive_req.lo};
                s_user  <= drive_req.cmd;
                s_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 2) == 0)
                    send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result backpressure
    always @(negedge clk) begin
        if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
                recv_stall = pick_gap();
        end
    end

    // Monitor: predict on command transactions, check result transactions
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_valid && s_ready === 1'b1) begin
                cmd_taken     = 1'b1;
                accepted_cnt++;
                taken_req.cmd = s_user;
                taken_req.lo  = s_data[31:0];
                taken_req.hi  = s_data[63:32];
                expected_draws.push_back(predict_draw(taken_req));
            end
            if (m_valid === 1'b1 && m_ready) begin
                if (expected_draws.size() == 0) begin
                    $error("unexpected result transaction: value=%h range_error=%b",
                           m_data, m_user);
                    fail_cnt++;
                end else begin
                    want_res = expected_draws.pop_front();
                    if (m_data !== want_res.value) begin
                        $error("value: expected %h, got %h", want_res.value, m_data);
                        fail_cnt++;
                    end
                    if (m_user !== want_res.range_error) begin
                        $error("range_error: expected %b, got %b",
                               want_res.range_error, m_user);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [31:0] phase_seeds [6];
        phase_seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                        $urandom(), $urandom(), $urandom()};

        // Directed pass on the reset seed; first draw is unseeded
        push_cmd(CMD_RAW,    32'h0,         32'h0);
        push_cmd(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
        push_cmd(CMD_RANGED, 32'h8000_0000, 32'h7fff_ffff);
        push_cmd(CMD_RANGED, 32'h7fff_ffff, 32'h8000_0000);
        push_cmd(CMD_RANGED, 32'h8000_0000, 32'h8000_0000);
        push_cmd(CMD_RANGED, 32'h7fff_ffff, 32'h7fff_ffff);
        push_cmd(CMD_RANGED, 32'h0,         32'h0);
        push_cmd(CMD_RANGED, 32'd5,         32'd6);
        push_cmd(CMD_RANGED, -32'sd10,      -32'sd20);
        push_cmd(CMD_RANGED, 32'h0,         32'h1);
        push_cmd(CMD_RAW,    32'hffff_ffff, 32'h0);
        push_cmd(CMD_RESEED, 32'h0,         32'h0);
        push_cmd(CMD_RAW,    32'h0,         32'hffff_ffff);
        push_cmd(CMD_RANGED, 32'h0,         32'hffff_ffff);
        push_cmd(CMD_UNUSED, 32'h0,         32'h0);
        push_cmd(CMD_RANGED, 32'd1000,      -32'sd1000);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // Random phases, one seed each, sender held off between them
        for (int p = 0; p < 6; p++) begin
            write_seed(phase_seeds[p]);
            idle_on = (p != 2);
            push_cmd(CMD_RESEED, $urandom(), $urandom());
            for (int i = 0; i < PHASE_ITEMS; i++)
                begin
                    drive_req = rand_cmd();
                    push_cmd(drive_req.cmd, drive_req.lo, drive_req.hi);
                end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/mtrd_pkg.sv
src/mtrd_state_mem.sv
src/mtrd_divider.sv
src/mersenne_twister_ranged_draw_core.sv
tb/mersenne_twister_ranged_draw_core_tb.sv
